// ===== rtl/rld_pkg.sv =====
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants of the run-length row decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned COUNT_W    = 7;
   localparam int unsigned POS_W      = 16;
   localparam int unsigned NCOUNT_W   = 2;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [COUNT_W-1:0] COUNT_ZERO = '0;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
   localparam logic [POS_W-1:0]   ROW_WIDTH_RESET = POS_W'(1);

   typedef enum logic [1:0] {
      PH_CTRL = 2'd0,
      PH_LIT  = 2'd1,
      PH_REP  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CMD_ROW_END = 2'd0,
      CMD_LITERAL = 2'd1,
      CMD_REPEAT  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [BYTE_W-1:0]   value;
      logic [COUNT_W-1:0]  count;
   } cmd_type;

endpackage

// ===== rtl/rle_row_decoder.sv =====
// ----------------------------------------------------------------------------
// rle_row_decoder
// Run-length row decoder, one compressed byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one compressed byte (control, literal or repeat value) per
//            transfer.
//   rsp_*  : decoded results, two pixels per transfer at most; tuser flags
//            row end and dropped pixels, tlast marks the final result of
//            one input byte.
//   csr_*  : row width write; always ready, write only while idle.
// Path: a taken byte's command is queued, then its result is registered.
// Throughput: one byte per cycle while the command queue has room; a repeat
//   byte with count c occupies the result stage for ceil(c/2) results, one
//   result per cycle unless the receiver stalls, so bytes behind it queue up (four-entry queue).
//   Control bytes with a nonzero count produce no result.
// Reset: synchronous; row position, phase and queue clear, row width = 1.
// Stall: a held rsp_tready freezes the result register; the queue absorbs
//   up to four commands before req_tready drops.
// ----------------------------------------------------------------------------
module rle_row_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] pixel_first, [15:8] pixel_second,
                                    // [17:16] valid_count, [23:18] zero
   output logic [1:0]  rsp_tuser,   // [0] row_done, [1] overflow
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // [15:0] row_width
);
   import rld_pkg::*;

   logic [POS_W-1:0] row_width_ff;
   cmd_type          push_cmd, head_cmd;
   logic             push, pop, empty, full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         row_width_ff <= csr_data;
      end
   end

   rld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_full   (full),
      .cmd_push   (push),
      .cmd_data   (push_cmd)
   );

   rld_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head      (head_cmd),
      .empty     (empty),
      .full      (full)
   );

   rld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .row_width  (row_width_ff),
      .head       (head_cmd),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/rld_front.sv =====
// ----------------------------------------------------------------------------
// rld_front
// Accepts compressed bytes, tracks the control phase and issues commands.
// ----------------------------------------------------------------------------
module rld_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,   // [7:0] in_byte
   input  logic            cmd_full,
   output logic            cmd_push,
   output rld_pkg::cmd_type cmd_data
);
   import rld_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   run_left_ff, run_left_in;
   logic                 accept;
   logic [COUNT_W-1:0]   count;

   assign req_tready = !cmd_full;
   assign accept     = req_tvalid && req_tready;
   assign count      = req_tdata[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CTRL;
         run_left_ff <= COUNT_ZERO;
      end else if (accept) begin
         phase_ff    <= phase_in;
         run_left_ff <= run_left_in;
      end
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      run_left_in = run_left_ff;
      unique case (phase_ff)
         PH_LIT: begin
            run_left_in = run_left_ff - COUNT_ONE;
            phase_in    = (run_left_ff == COUNT_ONE) ? PH_CTRL : PH_LIT;
         end
         PH_REP: begin
            run_left_in = COUNT_ZERO;
            phase_in    = PH_CTRL;
         end
         default: begin
            run_left_in = count;
            if (count == COUNT_ZERO) begin
               phase_in = PH_CTRL;
            end else begin
               phase_in = req_tdata[BYTE_W-1] ? PH_LIT : PH_REP;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd_push       = 1'b0;
      cmd_data.kind  = CMD_ROW_END;
      cmd_data.value = req_tdata;
      cmd_data.count = COUNT_ONE;
      unique case (phase_ff)
         PH_LIT: begin
            cmd_push      = accept;
            cmd_data.kind = CMD_LITERAL;
         end
         PH_REP: begin
            cmd_push       = accept;
            cmd_data.kind  = CMD_REPEAT;
            cmd_data.count = run_left_ff;
         end
         default: begin
            cmd_push = accept && (count == COUNT_ZERO);
         end
      endcase
   end

endmodule

// ===== rtl/rld_fifo.sv =====
// ----------------------------------------------------------------------------
// rld_fifo
// Short command queue between the front and back sections.
// ----------------------------------------------------------------------------
module rld_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rld_pkg::cmd_type push_data,
   input  logic             pop,
   output rld_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);
   import rld_pkg::*;

   cmd_type                 entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   fill_ff;
   logic                    do_push, do_pop;

   assign empty   = (fill_ff == FIFO_CNT_W'(0));
   assign full    = (fill_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + FIFO_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - FIFO_CNT_W'(1);
         end
      end
   end

endmodule

// ===== rtl/rld_back.sv =====
// ----------------------------------------------------------------------------
// rld_back
// Executes commands: places pixels in the row, packs them up to two per result.
// ----------------------------------------------------------------------------
module rld_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [rld_pkg::POS_W-1:0] row_width,
   input  rld_pkg::cmd_type         head,
   input  logic                     empty,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [23:0]              rsp_tdata,  // [7:0] pixel_first, [15:8] pixel_second,
                                                // [17:16] valid_count, [23:18] zero
   output logic [1:0]               rsp_tuser,  // [0] row_done, [1] overflow
   output logic                     rsp_tlast   // last
);
   import rld_pkg::*;

   logic                  active_ff, active_in;
   cmd_type               work_ff, work_in;
   logic [POS_W-1:0]      row_pos_ff, row_pos_in;

   logic                  out_valid_ff;
   logic [BYTE_W-1:0]     out_first_ff, out_first_in;
   logic [BYTE_W-1:0]     out_second_ff, out_second_in;
   logic [NCOUNT_W-1:0]   out_n_ff, out_n_in;
   logic                  out_done_ff, out_done_in;
   logic                  out_ovf_ff, out_ovf_in;
   logic                  out_last_ff, out_last_in;

   cmd_type               cur;
   logic                  slot_free, emit;
   logic                  want_two, keep0, keep1;
   logic [COUNT_W-1:0]    remain;

   assign cur       = active_ff ? work_ff : head;
   assign slot_free = !out_valid_ff || rsp_tready;
   assign emit      = slot_free && (active_ff || !empty);
   assign pop       = emit && !active_ff;

   assign want_two = (cur.kind == CMD_REPEAT) && (cur.count >= COUNT_W'(2));
   assign keep0    = (row_pos_ff < row_width);
   assign keep1    = want_two && keep0
                     && (({1'b0, row_pos_ff} + (POS_W+1)'(1)) < {1'b0, row_width});
   assign remain   = cur.count - (want_two ? COUNT_W'(2) : COUNT_ONE);

   always_comb begin
      out_first_in  = '0;
      out_second_in = '0;
      out_n_in      = '0;
      out_done_in   = 1'b0;
      out_ovf_in    = 1'b0;
      out_last_in   = 1'b1;
      row_pos_in    = row_pos_ff;
      active_in     = 1'b0;
      work_in       = cur;
      unique case (cur.kind)
         CMD_ROW_END: begin
            out_done_in = 1'b1;
            row_pos_in  = '0;
         end
         CMD_LITERAL, CMD_REPEAT: begin
            out_n_in      = NCOUNT_W'(keep0) + NCOUNT_W'(keep1);
            out_first_in  = keep0 ? cur.value : '0;
            out_second_in = keep1 ? cur.value : '0;
            out_ovf_in    = !keep0 || (want_two && !keep1);
            out_last_in   = (remain == COUNT_ZERO);
            row_pos_in    = row_pos_ff + POS_W'(keep0) + POS_W'(keep1);
            active_in     = (remain != COUNT_ZERO);
            work_in.count = remain;
         end
         default: begin
            out_done_in = 1'b1;
            row_pos_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         row_pos_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            active_ff  <= active_in;
            row_pos_ff <= row_pos_in;
         end
         if (slot_free) begin
            out_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         work_ff       <= work_in;
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
         out_n_ff      <= out_n_in;
         out_done_ff   <= out_done_in;
         out_ovf_ff    <= out_ovf_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_n_ff, out_second_ff, out_first_ff};
   assign rsp_tuser  = {out_ovf_ff, out_done_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/rld_checker.sv =====
// ----------------------------------------------------------------------------
// rld_checker
// Port-level checks of the run-length row decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rld_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:16] != 2'd3)
      else $error("valid_count out of range");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && !rsp_tuser[1]
                                      && rsp_tdata[17:16] == 2'd0)
      else $error("row end result malformed");

   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17:16] != 2'd2 |-> rsp_tdata[15:8] == 8'd0)
      else $error("unused second pixel not zero");

   a_short_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] && rsp_tdata[17:16] == 2'd0 |-> rsp_tuser[1])
      else $error("empty pixel result without overflow");

endmodule

bind rle_row_decoder rld_checker u_rld_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/tb_rle_row_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_rle_row_decoder
// Self-checking bench for the run-length row decoder. A queue-fed driver
// sends compressed bytes in random bursts, the receiver stalls on its own
// pattern, and a monitor decodes every accepted byte in a local row model
// and checks each result transfer field by field. Row width is rewritten
// between phases while the decoder is idle.
// ----------------------------------------------------------------------------
module tb_rle_row_decoder;
   import rld_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam logic [7:0] LIT_FLAG = 8'h80;
   localparam logic [7:0] ROW_END  = 8'h00;

   typedef struct packed {
      logic [7:0] pix_a;
      logic [7:0] pix_b;
      logic [1:0] npix;
      logic       row_end;
      logic       dropped;
      logic       tail;
   } pix_pair_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MASK, RX_HOLD} rx_mode_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   // row model
   phase_type   dec_phase;
   logic [6:0]  run_count;
   logic [15:0] col_pos;
   logic [15:0] col_limit;

   logic [7:0]   comp_byte_q[$];
   pix_pair_type pair_q[$];

   logic        req_took;
   logic        csr_took;
   int unsigned err_count;
   int unsigned cycle_count;
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned rx_left;
   int unsigned rx_tick;
   rx_mode_type rx_mode;
   logic [7:0]  rx_mask;

   rle_row_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_error(input string msg);
      $display("%0t tb_rle_row_decoder error: %s", $time, msg);
      err_count++;
   endtask

   function automatic bit take_slot();
      if (col_pos < col_limit) begin
         col_pos = col_pos + 16'd1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic decode_byte(input logic [7:0] b);
      pix_pair_type e;
      int unsigned  left;
      int unsigned  want;
      int unsigned  n;
      logic         ovf;
      logic         kept;
      case (dec_phase)
         PH_LIT: begin
            kept = take_slot();
            e = '0;
            e.pix_a = kept ? b : 8'd0;
            e.npix = kept ? 2'd1 : 2'd0;
            e.dropped = !kept;
            e.tail = 1'b1;
            pair_q.push_back(e);
            run_count = run_count - 7'd1;
            if (run_count == COUNT_ZERO) dec_phase = PH_CTRL;
         end
         PH_REP: begin
            left = {25'd0, run_count};
            while (left > 0) begin
               want = (left >= 2) ? 2 : 1;
               n = 0;
               ovf = 1'b0;
               for (int i = 0; i < want; i++) begin
                  if (take_slot()) n++;
                  else ovf = 1'b1;
               end
               left -= want;
               e = '0;
               e.pix_a = (n >= 1) ? b : 8'd0;
               e.pix_b = (n >= 2) ? b : 8'd0;
               e.npix = n[1:0];
               e.dropped = ovf;
               e.tail = (left == 0);
               pair_q.push_back(e);
            end
            run_count = COUNT_ZERO;
            dec_phase = PH_CTRL;
         end
         default: begin
            if (b[6:0] == COUNT_ZERO) begin
               col_pos = '0;
               run_count = COUNT_ZERO;
               dec_phase = PH_CTRL;
               e = '0;
               e.row_end = 1'b1;
               e.tail = 1'b1;
               pair_q.push_back(e);
            end else begin
               run_count = b[6:0];
               dec_phase = b[7] ? PH_LIT : PH_REP;
            end
         end
      endcase
   endtask

   task automatic check_pair();
      pix_pair_type e;
      if (pair_q.size() == 0) begin
         report_error($sformatf("unexpected result transfer %h", rsp_tdata));
         return;
      end
      e = pair_q.pop_front();
      if (rsp_tdata[7:0] !== e.pix_a)
         report_error($sformatf("pixel_first %h, expected %h", rsp_tdata[7:0], e.pix_a));
      if (rsp_tdata[15:8] !== e.pix_b)
         report_error($sformatf("pixel_second %h, expected %h", rsp_tdata[15:8], e.pix_b));
      if (rsp_tdata[17:16] !== e.npix)
         report_error($sformatf("valid_count %0d, expected %0d", rsp_tdata[17:16], e.npix));
      if (rsp_tdata[23:18] !== 6'd0)
         report_error($sformatf("tdata pad bits %h, expected zero", rsp_tdata[23:18]));
      if (rsp_tuser[0] !== e.row_end)
         report_error($sformatf("row_done %b, expected %b", rsp_tuser[0], e.row_end));
      if (rsp_tuser[1] !== e.dropped)
         report_error($sformatf("overflow %b, expected %b", rsp_tuser[1], e.dropped));
      if (rsp_tlast !== e.tail)
         report_error($sformatf("tlast %b, expected %b", rsp_tlast, e.tail));
   endtask

   // monitor: model update and result check
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) col_limit = csr_data;
         if (req_tvalid && req_tready) decode_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) check_pair();
      end
      req_took <= !reset && req_tvalid && req_tready;
      csr_took <= !reset && csr_valid && csr_ready;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_rle_row_decoder: FAIL");
         $finish;
      end
   end

   // request driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (req_took) void'(comp_byte_q.pop_front());
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (comp_byte_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= comp_byte_q[0];
            burst_left--;
            if (burst_left == 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(32, 96);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = $urandom_range(1, 6);
               end
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result stall pattern
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 4));
         rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 20) : $urandom_range(20, 200);
         rx_mask = 8'($urandom_range(1, 255));
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         RX_MASK:   rsp_tready <= rx_mask[rx_tick[2:0]];
         default:   rsp_tready <= 1'b0;
      endcase
   end

   task automatic wait_idle();
      while (!(comp_byte_q.size() == 0 && !req_tvalid && pair_q.size() == 0))
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_width(input logic [15:0] w);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= w;
      do @(negedge clock); while (!csr_took);
      csr_valid <= 1'b0;
   endtask

   task automatic push_row_stream(input int unsigned target);
      int unsigned added;
      int unsigned r;
      int unsigned cnt;
      int unsigned body;
      added = 0;
      while (added < target) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            comp_byte_q.push_back(8'($urandom_range(0, 255)));
            added++;
         end else if (r < 18) begin
            comp_byte_q.push_back(ROW_END | ($urandom_range(0, 1) ? LIT_FLAG : 8'd0));
            added++;
         end else if (r < 55) begin
            cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
            body = ($urandom_range(0, 19) == 0) ? $urandom_range(0, cnt) : cnt;
            comp_byte_q.push_back(LIT_FLAG | {1'b0, cnt[6:0]});
            repeat (body) comp_byte_q.push_back(8'($urandom_range(0, 255)));
            added += body + 1;
         end else begin
            cnt = $urandom_range(0, 2) == 0 ? $urandom_range(1, 127) : $urandom_range(1, 9);
            comp_byte_q.push_back({1'b0, cnt[6:0]});
            comp_byte_q.push_back(8'($urandom_range(0, 255)));
            added += 2;
         end
      end
   endtask

   initial begin
      logic [15:0] widths[6];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      req_took = 1'b0;
      csr_took = 1'b0;
      err_count = 0;
      cycle_count = 0;
      burst_left = 4;
      gap_left = 0;
      rx_left = 0;
      rx_tick = 0;
      dec_phase = PH_CTRL;
      run_count = COUNT_ZERO;
      col_pos = '0;
      col_limit = ROW_WIDTH_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: row ends, literals, repeats, dropped pixels, longest run
      write_width(16'd5);
      comp_byte_q = '{ROW_END, LIT_FLAG, LIT_FLAG | 8'd3, 8'h00, 8'hFF, 8'hA5,
                      8'h03, 8'h7E, LIT_FLAG | 8'd1, 8'h55, 8'h7F, 8'hFF,
                      ROW_END, 8'h01, 8'h00, 8'h02, 8'hAA, LIT_FLAG | 8'd2,
                      8'h5A, 8'hC3, ROW_END};
      wait_idle();

      widths = '{16'd1, 16'hFFFF, 16'($urandom_range(2, 16)),
                 16'($urandom_range(17, 300)), 16'hFFFF, 16'd1};
      foreach (widths[i]) begin
         write_width(widths[i]);
         push_row_stream(55);
         wait_idle();
      end

      if (err_count == 0) $display("tb_rle_row_decoder: PASS");
      else $display("tb_rle_row_decoder: FAIL");
      $finish;
   end

endmodule
